// ----- rtl/periodic_priority_task_dispatcher_macros.svh -----
// Assertion macros shared by the dispatcher RTL.
`ifndef PERIODIC_PRIORITY_TASK_DISPATCHER_MACROS_SVH
`define PERIODIC_PRIORITY_TASK_DISPATCHER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PPD_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define PPD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define PPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PPD_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg)
`define PPD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define PPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- rtl/ppd_pkg.sv -----
// Shared constants and types of the periodic priority task dispatcher.
`timescale 1ns / 1ps
`default_nettype none
package ppd_pkg;
    localparam int NUM_TASKS    = 8;
    localparam int MAX_DISPATCH = 16;

    localparam int DATA_W   = 32;
    localparam int ID_W     = 8;
    localparam int PRIO_W   = 8;
    localparam int FUNC_W   = 3;
    localparam int STATUS_W = 2;
    localparam int RUN_ID_W = 3;

    localparam logic [FUNC_W-1:0] FUNC_CREATE  = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_SUSPEND = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_RESUME  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_RUN     = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_MORE    = 2'd2;

    typedef struct packed {
        logic [DATA_W-1:0] period;
        logic [DATA_W-1:0] deadline;
        logic [PRIO_W-1:0] prio;
    } t_slot;

    typedef struct packed {
        logic                latch;
        logic                create_wr;
        logic                suspend;
        logic                resume_rd;
        logic                resume_wr;
        logic                clear_all;
        logic                pass_start;
        logic                scan_start;
        logic                scan_rd;
        logic                dispatch;
        logic                out_load;
        logic [STATUS_W-1:0] out_status;
        logic                out_disp;
        logic                out_last;
    } t_dp_cmd;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              id_ok;
        logic              period_zero;
        logic              slot_used;
        logic              scan_last;
        logic              found;
        logic              room;
        logic              pend;
        logic              out_free;
    } t_dp_sts;
endpackage
`default_nettype wire

// ----- rtl/ppd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module ppd_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

// ----- rtl/ppd_dpath.sv -----
// Datapath: slot table, due-slot scan, deadline adder and result register.
`timescale 1ns / 1ps
`default_nettype none
`include "periodic_priority_task_dispatcher_macros.svh"
module ppd_dpath #(
    parameter int NUM_TASKS    = ppd_pkg::NUM_TASKS,
    parameter int MAX_DISPATCH = ppd_pkg::MAX_DISPATCH
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire ppd_pkg::t_dp_cmd               i_cmd,
    output ppd_pkg::t_dp_sts                    o_sts,
    input  wire logic [ppd_pkg::FUNC_W-1:0]     i_func,
    input  wire logic [ppd_pkg::ID_W-1:0]       i_task_id,
    input  wire logic [ppd_pkg::DATA_W-1:0]     i_period,
    input  wire logic [ppd_pkg::PRIO_W-1:0]     i_prio_level,
    input  wire logic [ppd_pkg::DATA_W-1:0]     i_now,
    input  wire logic                           i_out_ready,
    output logic                                o_out_valid,
    output logic [ppd_pkg::STATUS_W-1:0]        o_status,
    output logic [ppd_pkg::RUN_ID_W-1:0]        o_run_id,
    output logic                                o_dispatched,
    output logic                                o_last
);
    localparam int IDX_W  = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int CNT_W  = $clog2(MAX_DISPATCH + 1);
    localparam int SLOT_W = $bits(ppd_pkg::t_slot);
    localparam int DW     = ppd_pkg::DATA_W;

    // latched command
    logic [ppd_pkg::FUNC_W-1:0] r_func;
    logic [ppd_pkg::ID_W-1:0]   r_id;
    logic [DW-1:0]              r_period;
    logic [ppd_pkg::PRIO_W-1:0] r_prio;
    logic [DW-1:0]              r_now;

    logic [NUM_TASKS-1:0] r_used;
    logic [NUM_TASKS-1:0] r_active;

    logic [IDX_W-1:0]     r_scan_idx;
    logic                 r_cmp_valid;
    logic [IDX_W-1:0]     r_cmp_idx;
    logic                 r_found;
    logic [IDX_W-1:0]     r_best_idx;
    ppd_pkg::t_slot       r_best;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_pend;
    logic [IDX_W-1:0]     r_pend_idx;

    logic                          r_out_valid;
    logic [ppd_pkg::STATUS_W-1:0]  r_out_status;
    logic [ppd_pkg::RUN_ID_W-1:0]  r_out_run_id;
    logic                          r_out_disp;
    logic                          r_out_last;

    logic [IDX_W-1:0]  w_id_idx;
    logic [IDX_W-1:0]  w_raddr;
    logic [IDX_W-1:0]  w_waddr;
    logic              w_we;
    logic [SLOT_W-1:0] w_rdata;
    ppd_pkg::t_slot    w_rd;
    ppd_pkg::t_slot    w_wr;
    logic [DW-1:0]     w_base;
    logic [DW-1:0]     w_inc;
    logic [DW-1:0]     w_sum;
    logic [DW-1:0]     w_diff;
    logic              w_due;
    logic              w_take;

    assign w_id_idx = r_id[IDX_W-1:0];
    assign w_rd     = ppd_pkg::t_slot'(w_rdata);
    assign w_raddr  = i_cmd.resume_rd ? w_id_idx : r_scan_idx;
    assign w_waddr  = i_cmd.dispatch ? r_best_idx : w_id_idx;
    assign w_we     = i_cmd.create_wr | i_cmd.resume_wr | i_cmd.dispatch;

    always_comb begin
        w_base = r_now;
        w_inc  = r_period;
        if (i_cmd.dispatch) begin
            w_base = r_best.deadline;
            w_inc  = r_best.period;
        end else if (i_cmd.resume_wr) begin
            w_inc  = w_rd.period;
        end
        w_sum = w_base + w_inc;
        w_wr  = '{period: r_period, deadline: w_sum, prio: r_prio};
        if (i_cmd.dispatch) begin
            w_wr = '{period: r_best.period, deadline: w_sum, prio: r_best.prio};
        end else if (i_cmd.resume_wr) begin
            w_wr = '{period: w_rd.period, deadline: w_sum, prio: w_rd.prio};
        end
    end

    ppd_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (NUM_TASKS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (SLOT_W'(w_wr)),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // due when (now - deadline) mod 2^32 <= 0x7FFFFFFF
    assign w_diff = r_now - w_rd.deadline;
    assign w_due  = r_cmp_valid & r_used[r_cmp_idx] & r_active[r_cmp_idx] & ~w_diff[DW-1];
    assign w_take = w_due & (~r_found | (w_rd.prio < r_best.prio));

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_func   <= i_func;
            r_id     <= i_task_id;
            r_period <= i_period;
            r_prio   <= i_prio_level;
            r_now    <= i_now;
        end
        if (w_take && !i_cmd.scan_start) begin
            r_best_idx <= r_cmp_idx;
            r_best     <= w_rd;
        end
        if (i_cmd.dispatch) begin
            r_pend_idx <= r_best_idx;
        end
        r_cmp_idx <= r_scan_idx;
        if (i_cmd.out_load) begin
            r_out_status <= i_cmd.out_status;
            r_out_run_id <= i_cmd.out_disp ? ppd_pkg::RUN_ID_W'(r_pend_idx) : '0;
            r_out_disp   <= i_cmd.out_disp;
            r_out_last   <= i_cmd.out_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used      <= '0;
            r_active    <= '0;
            r_scan_idx  <= '0;
            r_cmp_valid <= 1'b0;
            r_found     <= 1'b0;
            r_cnt       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear_all) begin
                r_used   <= '0;
                r_active <= '0;
            end else if (i_cmd.create_wr) begin
                r_used[w_id_idx]   <= 1'b1;
                r_active[w_id_idx] <= 1'b1;
            end else if (i_cmd.resume_wr) begin
                r_active[w_id_idx] <= 1'b1;
            end else if (i_cmd.suspend) begin
                r_active[w_id_idx] <= 1'b0;
            end

            r_cmp_valid <= i_cmd.scan_rd;
            if (i_cmd.scan_start) begin
                r_scan_idx <= '0;
                r_found    <= 1'b0;
            end else begin
                if (i_cmd.scan_rd && !o_sts.scan_last) begin
                    r_scan_idx <= r_scan_idx + 1'b1;
                end
                if (w_take) begin
                    r_found <= 1'b1;
                end
            end

            if (i_cmd.pass_start) begin
                r_cnt  <= '0;
                r_pend <= 1'b0;
            end else if (i_cmd.dispatch) begin
                r_cnt  <= r_cnt + 1'b1;
                r_pend <= 1'b1;
            end

            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts.func        = r_func;
        o_sts.id_ok       = (r_id < ppd_pkg::ID_W'(NUM_TASKS));
        o_sts.period_zero = (r_period == '0);
        o_sts.slot_used   = r_used[w_id_idx];
        o_sts.scan_last   = (r_scan_idx == IDX_W'(NUM_TASKS - 1));
        o_sts.found       = r_found;
        o_sts.room        = (r_cnt < CNT_W'(MAX_DISPATCH));
        o_sts.pend        = r_pend;
        o_sts.out_free    = ~r_out_valid | i_out_ready;
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_run_id     = r_out_run_id;
    assign o_dispatched = r_out_disp;
    assign o_last       = r_out_last;

    `PPD_ASSERT_ALWAYS(a_cnt_bound, i_clk, i_rst_n, r_cnt <= CNT_W'(MAX_DISPATCH), "dispatch count over limit")
    `PPD_ASSERT_ALWAYS(a_active_used, i_clk, i_rst_n, (r_active & ~r_used) == '0, "active slot not in use")
    `PPD_ASSERT_NEXT(a_disp_pend, i_clk, i_rst_n, i_cmd.dispatch, r_pend, "dispatch left no pending result")
endmodule
`default_nettype wire

// ----- rtl/ppd_ctrl.sv -----
// Controller: command decode, scan sequencing and result emission.
`timescale 1ns / 1ps
`default_nettype none
`include "periodic_priority_task_dispatcher_macros.svh"
module ppd_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire ppd_pkg::t_dp_sts i_sts,
    output ppd_pkg::t_dp_cmd      o_cmd
);
    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DECODE   = 3'd1;
    localparam logic [2:0] S_RESP     = 3'd2;
    localparam logic [2:0] S_RES_WR   = 3'd3;
    localparam logic [2:0] S_SCAN     = 3'd4;
    localparam logic [2:0] S_SCAN_END = 3'd5;
    localparam logic [2:0] S_DECIDE   = 3'd6;

    logic [2:0]                   r_state;
    logic [2:0]                   n_state;
    logic [ppd_pkg::STATUS_W-1:0] r_resp;
    logic [ppd_pkg::STATUS_W-1:0] n_resp;

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        n_state    = r_state;
        n_resp     = r_resp;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_RESP;
                n_resp  = ppd_pkg::STATUS_INVALID;
                unique case (i_sts.func)
                    ppd_pkg::FUNC_CREATE: begin
                        if (i_sts.id_ok && !i_sts.period_zero) begin
                            o_cmd.create_wr = 1'b1;
                            n_resp          = ppd_pkg::STATUS_OK;
                        end
                    end
                    ppd_pkg::FUNC_SUSPEND: begin
                        if (i_sts.id_ok && i_sts.slot_used) begin
                            o_cmd.suspend = 1'b1;
                            n_resp        = ppd_pkg::STATUS_OK;
                        end
                    end
                    ppd_pkg::FUNC_RESUME: begin
                        if (i_sts.id_ok && i_sts.slot_used) begin
                            o_cmd.resume_rd = 1'b1;
                            n_state         = S_RES_WR;
                        end
                    end
                    ppd_pkg::FUNC_RUN: begin
                        o_cmd.pass_start = 1'b1;
                        o_cmd.scan_start = 1'b1;
                        n_state          = S_SCAN;
                    end
                    ppd_pkg::FUNC_CLEAR: begin
                        o_cmd.clear_all = 1'b1;
                        n_resp          = ppd_pkg::STATUS_OK;
                    end
                    default: begin
                        n_resp = ppd_pkg::STATUS_INVALID;
                    end
                endcase
            end
            S_RES_WR: begin
                o_cmd.resume_wr = 1'b1;
                n_resp          = ppd_pkg::STATUS_OK;
                n_state         = S_RESP;
            end
            S_RESP: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_status = r_resp;
                    o_cmd.out_last   = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            S_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_SCAN_END;
                end
            end
            S_SCAN_END: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (i_sts.found && i_sts.room) begin
                    // previous dispatch is not the final beat
                    if (!i_sts.pend || i_sts.out_free) begin
                        o_cmd.out_load   = i_sts.pend;
                        o_cmd.out_status = ppd_pkg::STATUS_OK;
                        o_cmd.out_disp   = 1'b1;
                        o_cmd.dispatch   = 1'b1;
                        o_cmd.scan_start = 1'b1;
                        n_state          = S_SCAN;
                    end
                end else if (i_sts.out_free) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_status = i_sts.found ? ppd_pkg::STATUS_MORE : ppd_pkg::STATUS_OK;
                    o_cmd.out_disp   = i_sts.pend;
                    o_cmd.out_last   = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_resp  <= ppd_pkg::STATUS_OK;
        end else begin
            r_state <= n_state;
            r_resp  <= n_resp;
        end
    end

    `PPD_ASSERT_IMPL(a_load_free, i_clk, i_rst_n, o_cmd.out_load, i_sts.out_free, "result overwrites pending beat")
    `PPD_ASSERT_IMPL(a_disp_legal, i_clk, i_rst_n, o_cmd.dispatch, i_sts.found && i_sts.room, "dispatch without due slot or room")
    `PPD_ASSERT_NEXT(a_scan_end, i_clk, i_rst_n, (r_state == S_SCAN) && i_sts.scan_last, r_state == S_SCAN_END, "scan did not finish")
endmodule
`default_nettype wire

// ----- rtl/periodic_priority_task_dispatcher.sv -----
// Top level of the periodic priority task dispatcher.
//
// Input channel (i_in_valid / o_in_ready) carries one command per beat:
// create, suspend, resume, run pass or clear all, with the current tick.
// Output channel (o_out_valid / i_out_ready) returns result beats; the
// final beat of a command has o_last set.
// Commands are handled one at a time. A new command is taken in idle while
// the previous result beat still sits in the output register.
// Create, suspend, clear and invalid commands pass through a decode state
// and then a result state; resume adds a slot write state between them. A
// run pass scans the slot table once per dispatch and once more at the end,
// one slot per cycle through the slot RAM read port, each scan followed by
// a scan-end state and a decision state; a pass makes D dispatches, with
// D <= MAX_DISPATCH.
// If the receiver stalls, the block holds the beat and waits before
// emitting the next one; no work is lost.
// Reset clears all slots' used and active flags; no clearing pass is needed
// and a command can be accepted in the first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none
module periodic_priority_task_dispatcher #(
    parameter int NUM_TASKS    = ppd_pkg::NUM_TASKS,
    parameter int MAX_DISPATCH = ppd_pkg::MAX_DISPATCH
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic [ppd_pkg::FUNC_W-1:0]     i_func,
    input  wire logic [ppd_pkg::ID_W-1:0]       i_task_id,
    input  wire logic [ppd_pkg::DATA_W-1:0]     i_period,
    input  wire logic [ppd_pkg::PRIO_W-1:0]     i_prio_level,
    input  wire logic [ppd_pkg::DATA_W-1:0]     i_now,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic [ppd_pkg::STATUS_W-1:0]        o_status,
    output logic [ppd_pkg::RUN_ID_W-1:0]        o_run_id,
    output logic                                o_dispatched,
    output logic                                o_last
);
    ppd_pkg::t_dp_cmd w_cmd;
    ppd_pkg::t_dp_sts w_sts;

    ppd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    ppd_dpath #(
        .NUM_TASKS    (NUM_TASKS),
        .MAX_DISPATCH (MAX_DISPATCH)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_func       (i_func),
        .i_task_id    (i_task_id),
        .i_period     (i_period),
        .i_prio_level (i_prio_level),
        .i_now        (i_now),
        .i_out_ready  (i_out_ready),
        .o_out_valid  (o_out_valid),
        .o_status     (o_status),
        .o_run_id     (o_run_id),
        .o_dispatched (o_dispatched),
        .o_last       (o_last)
    );
endmodule
`default_nettype wire
